[hdl/wpm_pkg.sv]
// ----------------------------------------------------------------------------
// wpm_pkg: shared types and constants for the windowed pattern matcher
// Register indexes, field widths, the match-control struct, case folding.
// ----------------------------------------------------------------------------
package wpm_pkg;

  // Pattern storage is fixed by the register map: four 64-bit words
  localparam int unsigned PatRegBytes    = 32;
  localparam int unsigned PatWords       = 4;
  localparam int unsigned CfgDataW       = 64;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned PosW           = 16;
  localparam int unsigned LenW           = 6;
  localparam int unsigned PatternMaxBytes = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PAT_0_7   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PAT_8_15  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAT_16_23 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PAT_24_31 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PAT_LEN   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_DEPTH     = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_NOCASE    = 3'd7;

  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CaseDelta = 8'd32;

  // Precomputed region bounds and mode bits used by the compare stage
  typedef struct packed {
    logic              nocase;
    logic              len_ok;
    logic              depth_nz;
    logic [PosW:0]     lo_count;  // pattern_length + search_offset
    logic [PosW:0]     hi_count;  // search_offset + search_depth
  } match_cfg_t;

  // Control of the input stage register
  typedef struct packed {
    logic            valid;
    logic            last;
    logic [PosW-1:0] pos;
  } stage_ctl_t;

  // Fold ASCII upper case to lower case when enabled
  function automatic logic [7:0] fold_case(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= CharUpA) && (c <= CharUpZ)) begin
      r = c + CaseDelta;
    end
    return r;
  endfunction

endpackage

[hdl/wpm_in_if.sv]
// ----------------------------------------------------------------------------
// wpm_in_if: payload byte channel
// Valid/ready channel carrying one payload byte and its end-of-packet flag.
// ----------------------------------------------------------------------------
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] octet;
  logic       last_byte;

  modport source (output valid, output octet, output last_byte, input ready);
  modport sink   (input valid, input octet, input last_byte, output ready);
endinterface

[hdl/wpm_out_if.sv]
// ----------------------------------------------------------------------------
// wpm_out_if: match result channel
// Valid/ready channel carrying the per-packet match flag.
// ----------------------------------------------------------------------------
interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

[hdl/wpm_cfg.sv]
// ----------------------------------------------------------------------------
// wpm_cfg: configuration registers
// Holds the register map and derives the aligned, folded pattern, the byte
// enable mask and the search-region bounds into output registers from the map.
// ----------------------------------------------------------------------------
module wpm_cfg #(
  parameter int unsigned PATTERN_MAX_BYTES = wpm_pkg::PatternMaxBytes
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [wpm_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [wpm_pkg::CfgDataW-1:0]         cfg_wdata_i,
  output wpm_pkg::match_cfg_t                  mcfg_o,
  output logic [PATTERN_MAX_BYTES-1:0][7:0]    pat_align_o,
  output logic [PATTERN_MAX_BYTES-1:0]         pat_mask_o
);

  logic [wpm_pkg::PatWords-1:0][wpm_pkg::CfgDataW-1:0] pat_q;
  logic [wpm_pkg::LenW-1:0]                            len_q;
  logic [wpm_pkg::PosW-1:0]                            off_q;
  logic [wpm_pkg::PosW-1:0]                            dep_q;
  logic                                                nocase_q;

  logic [wpm_pkg::PatRegBytes-1:0][7:0] pat_flat;
  wpm_pkg::match_cfg_t                  mcfg_d, mcfg_q;
  logic [PATTERN_MAX_BYTES-1:0][7:0]    align_d, align_q;
  logic [PATTERN_MAX_BYTES-1:0]         mask_d, mask_q;

  // Write the register map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q    <= '0;
      len_q    <= '0;
      off_q    <= '0;
      dep_q    <= '0;
      nocase_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wpm_pkg::CFG_PAT_0_7:   pat_q[0] <= cfg_wdata_i;
        wpm_pkg::CFG_PAT_8_15:  pat_q[1] <= cfg_wdata_i;
        wpm_pkg::CFG_PAT_16_23: pat_q[2] <= cfg_wdata_i;
        wpm_pkg::CFG_PAT_24_31: pat_q[3] <= cfg_wdata_i;
        wpm_pkg::CFG_PAT_LEN:   len_q    <= cfg_wdata_i[wpm_pkg::LenW-1:0];
        wpm_pkg::CFG_OFFSET:    off_q    <= cfg_wdata_i[wpm_pkg::PosW-1:0];
        wpm_pkg::CFG_DEPTH:     dep_q    <= cfg_wdata_i[wpm_pkg::PosW-1:0];
        wpm_pkg::CFG_NOCASE:    nocase_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign pat_flat = pat_q;

  // Align the pattern so window entry k (newest first) meets pattern byte len-1-k
  always_comb begin
    logic [wpm_pkg::LenW-1:0] idx;
    for (int k = 0; k < PATTERN_MAX_BYTES; k++) begin
      idx        = len_q - wpm_pkg::LenW'(k) - wpm_pkg::LenW'(1);
      mask_d[k]  = (wpm_pkg::LenW'(k) < len_q);
      align_d[k] = wpm_pkg::fold_case(pat_flat[idx[4:0]], nocase_q);
    end
  end

  // Region bounds as byte counts (position + 1)
  always_comb begin
    mcfg_d.nocase   = nocase_q;
    mcfg_d.len_ok   = (len_q != '0) &&
                      (len_q <= wpm_pkg::LenW'(PATTERN_MAX_BYTES));
    mcfg_d.depth_nz = (dep_q != '0);
    mcfg_d.lo_count = (wpm_pkg::PosW+1)'(len_q) + {1'b0, off_q};
    mcfg_d.hi_count = {1'b0, off_q} + {1'b0, dep_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcfg_q  <= '0;
      align_q <= '0;
      mask_q  <= '0;
    end else begin
      mcfg_q  <= mcfg_d;
      align_q <= align_d;
      mask_q  <= mask_d;
    end
  end

  assign mcfg_o      = mcfg_q;
  assign pat_align_o = align_q;
  assign pat_mask_o  = mask_q;

endmodule

[hdl/wpm_window.sv]
// ----------------------------------------------------------------------------
// wpm_window: input stage
// Accepts payload bytes, shifts them into the byte window and registers the
// byte position and end-of-packet flag alongside.
// ----------------------------------------------------------------------------
module wpm_window #(
  parameter int unsigned PATTERN_MAX_BYTES = wpm_pkg::PatternMaxBytes
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  wpm_in_if.sink                            req,
  input  logic                              take_i,
  output wpm_pkg::stage_ctl_t               ctl_o,
  output logic [PATTERN_MAX_BYTES-1:0][7:0] window_o
);

  localparam logic [wpm_pkg::PosW-1:0] PosMax = '1;

  logic [PATTERN_MAX_BYTES-1:0][7:0] win_q;
  logic [wpm_pkg::PosW-1:0]          cnt_q;
  wpm_pkg::stage_ctl_t               ctl_q;
  logic                              accept;

  // Stage is free when empty or draining this cycle
  assign req.ready = !ctl_q.valid || take_i;
  assign accept    = req.valid && req.ready;

  // Advance position counter; saturate, restart after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ctl_q <= '0;
    end else begin
      if (accept) begin
        ctl_q.valid <= 1'b1;
        ctl_q.last  <= req.last_byte;
        ctl_q.pos   <= cnt_q;
        if (req.last_byte) begin
          cnt_q <= '0;
        end else if (cnt_q != PosMax) begin
          cnt_q <= cnt_q + wpm_pkg::PosW'(1);
        end
      end else if (take_i) begin
        ctl_q.valid <= 1'b0;
      end
    end
  end

  // Shift the new byte into entry 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (accept) begin
      win_q <= {win_q[PATTERN_MAX_BYTES-2:0], req.octet};
    end
  end

  assign ctl_o    = ctl_q;
  assign window_o = win_q;

endmodule

[hdl/wpm_match.sv]
// ----------------------------------------------------------------------------
// wpm_match: compare and result stage
// Compares the window against the aligned pattern, checks the search region,
// accumulates the per-packet hit flag and holds the result for the receiver.
// ----------------------------------------------------------------------------
module wpm_match #(
  parameter int unsigned PATTERN_MAX_BYTES = wpm_pkg::PatternMaxBytes
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wpm_pkg::stage_ctl_t               ctl_i,
  input  logic [PATTERN_MAX_BYTES-1:0][7:0] window_i,
  input  wpm_pkg::match_cfg_t               mcfg_i,
  input  logic [PATTERN_MAX_BYTES-1:0][7:0] pat_align_i,
  input  logic [PATTERN_MAX_BYTES-1:0]      pat_mask_i,
  output logic                              take_o,
  wpm_out_if.source                         rsp
);

  logic [PATTERN_MAX_BYTES-1:0] byte_ok;
  logic [wpm_pkg::PosW:0]       count;
  logic                         in_region;
  logic                         hit;
  logic                         found_q;
  logic                         out_valid_q;
  logic                         matched_q;

  // Per-byte compare; unused positions pass
  always_comb begin
    for (int k = 0; k < PATTERN_MAX_BYTES; k++) begin
      byte_ok[k] = !pat_mask_i[k] ||
                   (wpm_pkg::fold_case(window_i[k], mcfg_i.nocase) == pat_align_i[k]);
    end
  end

  // Occurrence must lie wholly inside the search region
  assign count     = {1'b0, ctl_i.pos} + (wpm_pkg::PosW+1)'(1);
  assign in_region = (count >= mcfg_i.lo_count) &&
                     (!mcfg_i.depth_nz || (count <= mcfg_i.hi_count));
  assign hit       = mcfg_i.len_ok && in_region && (&byte_ok);

  // Drain the input stage unless a last byte meets a full result register
  assign take_o = ctl_i.valid && (!ctl_i.last || !out_valid_q || rsp.ready);

  // Accumulate hits; emit the result on the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o && ctl_i.last) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      if (take_o) begin
        if (ctl_i.last) begin
          found_q <= 1'b0;
        end else begin
          found_q <= found_q || hit;
        end
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q <= 1'b0;
    end else if (take_o && ctl_i.last) begin
      matched_q <= found_q || hit;
    end
  end

  assign rsp.valid   = out_valid_q;
  assign rsp.matched = matched_q;

endmodule

[hdl/windowed_pattern_match.sv]
// ----------------------------------------------------------------------------
// windowed_pattern_match: exact pattern search in a packet payload
// Reports per packet whether the configured pattern occurs inside the region
// set by offset and depth, with optional ASCII case folding.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one payload byte per request with last_byte on the final
//   byte; rsp_o carries one matched flag per packet, after its last byte.
//   Configuration goes through cfg_we_i / cfg_index_i / cfg_wdata_i while the
//   block is idle; a write takes effect for bytes accepted from the next cycle.
//   Throughput: one byte per cycle, set by the parallel compare of the whole
//   window against the pattern, unless a last byte waits on a full result register.
//   After the edge that accepts the last byte, the result passes through the
//   input stage register, then the result register, and is then valid.
//   Reset clears registers, window, byte position and hit flag; there is no
//   clearing pass and bytes are accepted right after reset.
//   When the receiver stalls, the result register holds; bytes of the next
//   packet keep flowing until its own last byte reaches the compare stage,
//   which then waits for the result register to drain.
//   Positions saturate at 65535.
// ----------------------------------------------------------------------------
module windowed_pattern_match #(
  parameter int unsigned PATTERN_MAX_BYTES = wpm_pkg::PatternMaxBytes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  wpm_in_if.sink                       req_i,
  wpm_out_if.source                    rsp_o,
  input  logic                         cfg_we_i,
  input  logic [wpm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wpm_pkg::CfgDataW-1:0] cfg_wdata_i
);

  wpm_pkg::match_cfg_t               mcfg;
  logic [PATTERN_MAX_BYTES-1:0][7:0] pat_align;
  logic [PATTERN_MAX_BYTES-1:0]      pat_mask;
  wpm_pkg::stage_ctl_t               ctl;
  logic [PATTERN_MAX_BYTES-1:0][7:0] window;
  logic                              take;

  wpm_cfg #(
    .PATTERN_MAX_BYTES(PATTERN_MAX_BYTES)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mcfg_o      (mcfg),
    .pat_align_o (pat_align),
    .pat_mask_o  (pat_mask)
  );

  wpm_window #(
    .PATTERN_MAX_BYTES(PATTERN_MAX_BYTES)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req_i),
    .take_i   (take),
    .ctl_o    (ctl),
    .window_o (window)
  );

  wpm_match #(
    .PATTERN_MAX_BYTES(PATTERN_MAX_BYTES)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .window_i    (window),
    .mcfg_i      (mcfg),
    .pat_align_i (pat_align),
    .pat_mask_i  (pat_mask),
    .take_o      (take),
    .rsp         (rsp_o)
  );

endmodule
